// File: hw/rtl/ps2_aux_port_controller_defines.svh
// Assertion macros for the PS/2 auxiliary port controller checker.
// Standalone header, no dependencies; the macros expect clk_i and rst_ni in scope.
`ifndef PS2_AUX_PORT_CONTROLLER_DEFINES_SVH
`define PS2_AUX_PORT_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PS2AP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PS2AP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ps2ap_pkg.sv
// Shared types and constants for the PS/2 auxiliary port controller.
// No dependencies; used by the interfaces, the top level and the checker.
package ps2ap_pkg;

  // Request codes carried in req_type
  typedef enum logic [2:0] {
    REQ_DATA_RD   = 3'd0,
    REQ_STATUS_RD = 3'd1,
    REQ_DATA_WR   = 3'd2,
    REQ_CTRL_WR   = 3'd3,
    REQ_POLL      = 3'd4
  } req_type_e;

  // Poll sequencer phases
  typedef enum logic [1:0] {
    PH_IBF  = 2'd0,  // check input buffer
    PH_MAIN = 2'd1,  // check device
    PH_SEND = 2'd2,  // command handed over, waiting for device to take it
    PH_SCAN = 2'd3   // waiting for a response byte
  } poll_phase_e;

  // Status register bit positions
  localparam int unsigned StDevIdle = 0;
  localparam int unsigned StRxFull  = 1;
  localparam int unsigned StTxIdle  = 2;
  localparam int unsigned StReset   = 3;
  localparam int unsigned StIntsOn  = 4;
  localparam int unsigned StClear   = 6;
  localparam int unsigned StEnable  = 7;

  // Control write merge masks: kept bits and host-writable bits
  localparam logic [7:0] CtrlKeepMask  = 8'h27;
  localparam logic [7:0] CtrlWriteMask = 8'hD8;

  // Reset values
  localparam logic [7:0] StatusReset  = 8'h05;
  localparam logic [7:0] OutByteReset = 8'hFF;
  localparam logic [7:0] IdleReadData = 8'hFF;

  // Input item
  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] wdata;
    logic       dev_cmd_pending;
    logic       dev_byte_valid;
    logic [7:0] dev_byte;
  } req_t;

  // Result item
  typedef struct packed {
    logic [7:0] read_data;
    logic       cmd_valid;
    logic [7:0] cmd_byte;
    logic       take_dev_byte;
    logic       irq_pulse;
  } rsp_t;

endpackage

// File: hw/rtl/ps2ap_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on ps2ap_pkg for the payload types.
interface ps2ap_req_if;
  logic              valid;
  logic              ready;
  ps2ap_pkg::req_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ps2ap_rsp_if;
  logic              valid;
  logic              ready;
  ps2ap_pkg::rsp_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/ps2_aux_port_controller.sv
// Top level of the PS/2 auxiliary port controller (host side).
// Depends on ps2ap_pkg and the channel interfaces in ps2ap_if.sv.
//
// Usage:
//   in_i  (sink)   : one request per transfer: data read, status read, data
//                    write, control write or poll tick, plus the device-side
//                    flags sampled for that request.
//   out_o (source) : exactly one result per request: read byte, command
//                    byte for the device, byte-taken flag and interrupt pulse.
// Result: registered, and valid in the cycle after the request transfer.
// Throughput: one request per cycle; all state updates and the result are
// computed in one pass of logic between the request and the result register.
// Stall: when the result register holds an untaken result and out_o.ready is
// low, in_i.ready drops; a result taken in the same cycle frees the slot, so
// requests keep flowing back to back.
// Reset: status 0x05 (device idle, transmit idle), command byte 0x00, output
// byte 0xFF, poll sequencer in the input-buffer check phase, no result held.
module ps2_aux_port_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  ps2ap_req_if.sink           in_i,
  ps2ap_rsp_if.source         out_o
);

  // Architectural state
  logic [7:0]             status_q, status_d;
  logic [7:0]             in_byte_q, in_byte_d;
  logic [7:0]             out_byte_q, out_byte_d;
  ps2ap_pkg::poll_phase_e phase_q, phase_d;

  // Result register
  logic                   rsp_valid_q;
  ps2ap_pkg::rsp_t        rsp_q, rsp_d;

  ps2ap_pkg::req_t        req;
  logic                   in_fire;
  logic                   is_poll;
  logic                   tx_idle, rx_full, enable, ints_on;
  logic                   do_start, do_scan;

  assign req     = in_i.payload;
  assign in_fire = in_i.valid & in_i.ready;

  // Accept when the result slot is empty or being drained this cycle
  assign in_i.ready    = ~rsp_valid_q | out_o.ready;
  assign out_o.valid   = rsp_valid_q;
  assign out_o.payload = rsp_q;

  assign tx_idle = status_q[ps2ap_pkg::StTxIdle];
  assign rx_full = status_q[ps2ap_pkg::StRxFull];
  assign enable  = status_q[ps2ap_pkg::StEnable];
  assign ints_on = status_q[ps2ap_pkg::StIntsOn];
  assign is_poll = (req.req_type == ps2ap_pkg::REQ_POLL);

  // Poll actions: forward pending command, or latch an offered device byte
  assign do_start = is_poll & ~tx_idle &
                    ((phase_q == ps2ap_pkg::PH_IBF) | (phase_q == ps2ap_pkg::PH_MAIN));
  assign do_scan  = is_poll & req.dev_byte_valid &
                    (((phase_q == ps2ap_pkg::PH_MAIN) & tx_idle) |
                     (phase_q == ps2ap_pkg::PH_SCAN));

  // Poll sequencer next state
  always_comb begin
    phase_d = phase_q;
    if (is_poll) begin
      case (phase_q)
        ps2ap_pkg::PH_IBF: begin
          if (!tx_idle) begin
            phase_d = ps2ap_pkg::PH_SEND;
          end else if (!rx_full && enable) begin
            phase_d = ps2ap_pkg::PH_MAIN;
          end
        end
        ps2ap_pkg::PH_MAIN: begin
          phase_d = tx_idle ? ps2ap_pkg::PH_IBF : ps2ap_pkg::PH_SEND;
        end
        ps2ap_pkg::PH_SEND: begin
          if (!req.dev_cmd_pending) begin
            phase_d = ps2ap_pkg::PH_SCAN;
          end
        end
        ps2ap_pkg::PH_SCAN: begin
          if (req.dev_byte_valid) begin
            phase_d = ps2ap_pkg::PH_IBF;
          end
        end
        default: begin
          phase_d = ps2ap_pkg::PH_IBF;
        end
      endcase
    end
  end

  // Register updates and result for the current request
  always_comb begin
    status_d  = status_q;
    in_byte_d = in_byte_q;
    out_byte_d = out_byte_q;

    rsp_d.read_data     = ps2ap_pkg::IdleReadData;
    rsp_d.cmd_valid     = 1'b0;
    rsp_d.cmd_byte      = '0;
    rsp_d.take_dev_byte = 1'b0;
    rsp_d.irq_pulse     = 1'b0;

    case (req.req_type)
      ps2ap_pkg::REQ_DATA_RD: begin
        rsp_d.read_data = out_byte_q;
        out_byte_d      = ps2ap_pkg::OutByteReset;
        status_d[ps2ap_pkg::StRxFull]  = 1'b0;
        status_d[ps2ap_pkg::StDevIdle] = 1'b1;
      end
      ps2ap_pkg::REQ_STATUS_RD: begin
        rsp_d.read_data = status_q;
      end
      ps2ap_pkg::REQ_DATA_WR: begin
        if (tx_idle && enable) begin
          in_byte_d = req.wdata;
          status_d[ps2ap_pkg::StTxIdle] = 1'b0;
        end
      end
      ps2ap_pkg::REQ_CTRL_WR: begin
        status_d = (status_q & ps2ap_pkg::CtrlKeepMask) |
                   (req.wdata & ps2ap_pkg::CtrlWriteMask);
        // clear or reset flushes the receive side and idles the port
        if (status_d[ps2ap_pkg::StClear] || status_d[ps2ap_pkg::StReset]) begin
          status_d[ps2ap_pkg::StRxFull]  = 1'b0;
          status_d[ps2ap_pkg::StDevIdle] = 1'b1;
          status_d[ps2ap_pkg::StTxIdle]  = 1'b1;
        end
      end
      ps2ap_pkg::REQ_POLL: begin
        if (do_start) begin
          status_d[ps2ap_pkg::StTxIdle] = 1'b1;
          status_d[ps2ap_pkg::StEnable] = 1'b1;
          rsp_d.cmd_valid = 1'b1;
          rsp_d.cmd_byte  = in_byte_q;
        end
        if (do_scan) begin
          status_d[ps2ap_pkg::StDevIdle] = 1'b0;
          status_d[ps2ap_pkg::StRxFull]  = 1'b1;
          out_byte_d          = req.dev_byte;
          rsp_d.take_dev_byte = 1'b1;
          rsp_d.irq_pulse     = ints_on;
        end
      end
      default: begin
        // unused codes leave the state alone
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= ps2ap_pkg::StatusReset;
      in_byte_q   <= '0;
      out_byte_q  <= ps2ap_pkg::OutByteReset;
      phase_q     <= ps2ap_pkg::PH_IBF;
      rsp_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        status_q    <= status_d;
        in_byte_q   <= in_byte_d;
        out_byte_q  <= out_byte_d;
        phase_q     <= phase_d;
        rsp_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

// File: hw/rtl/ps2ap_checker.sv
// Port-level checker for the PS/2 auxiliary port controller, bound to the top.
// Depends on ps2ap_pkg and ps2_aux_port_controller_defines.svh.
`include "ps2_aux_port_controller_defines.svh"

module ps2ap_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  ps2ap_pkg::rsp_t out_payload_i
);

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_valid_i & in_ready_i;
  assign out_stall = out_valid_i & ~out_ready_i;

  // Every request transfer yields a result in the next cycle
  `PS2AP_ASSERT_NEXT(a_result_follows, in_xfer, out_valid_i, "no result after request transfer")

  // A stalled result holds its payload
  `PS2AP_ASSERT_NEXT(a_stall_holds, out_stall, out_valid_i && $stable(out_payload_i), "stalled result changed")

  // Interrupt only for a latched device byte
  `PS2AP_ASSERT_SAME(a_irq_needs_take, out_valid_i && out_payload_i.irq_pulse, out_payload_i.take_dev_byte, "irq without byte taken")

  // A poll either forwards a command or latches a byte, never both; a command result reads 0xFF
  `PS2AP_ASSERT_SAME(a_cmd_exclusive, out_valid_i && out_payload_i.cmd_valid, !out_payload_i.take_dev_byte && out_payload_i.read_data == 8'hFF, "command and byte take overlap")

endmodule

bind ps2_aux_port_controller ps2ap_checker u_ps2ap_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);

// File: tb/sv/ps2_aux_port_controller_test.sv
// Self-checking testbench for the PS/2 auxiliary port controller (host side).
// Needs ps2ap_pkg, the channel interfaces in ps2ap_if.sv and the top level.
// A behavioral predictor runs next to the block and every result is checked.
module ps2_aux_port_controller_test;

  // Request codes outside the decoded range
  localparam logic [2:0] ReqUnusedFirst = 3'd5;
  localparam logic [2:0] ReqUnusedLast  = 3'd7;
  localparam int unsigned RandomItems   = 750;
  localparam int unsigned IdleLimit     = 1000;
  localparam int unsigned DrainCycles   = 4;

  logic clk_i;
  logic rst_ni;

  ps2ap_req_if req_ch ();
  ps2ap_rsp_if rsp_ch ();

  ps2_aux_port_controller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  // Predictor state
  logic [7:0]             status_q;
  logic [7:0]             cmd_byte_q;
  logic [7:0]             rx_byte_q;
  ps2ap_pkg::poll_phase_e phase_q;

  ps2ap_pkg::rsp_t        aux_result_q[$];
  ps2ap_pkg::rsp_t        want_rsp;
  int unsigned            err_cnt;
  int unsigned            n_sent;
  int unsigned            burst_left;
  bit                     gaps_on;
  int unsigned            hold_left;
  int unsigned            idle_cnt;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model of one request: updates the state copy and returns the result
  function automatic ps2ap_pkg::rsp_t aux_port_predict(input ps2ap_pkg::req_t item);
    ps2ap_pkg::rsp_t res;
    bit              scan;
    res = '0;
    res.read_data = ps2ap_pkg::IdleReadData;
    scan = 1'b0;
    case (item.req_type)
      ps2ap_pkg::REQ_DATA_RD: begin
        res.read_data = rx_byte_q;
        rx_byte_q = ps2ap_pkg::OutByteReset;
        status_q[ps2ap_pkg::StRxFull]  = 1'b0;
        status_q[ps2ap_pkg::StDevIdle] = 1'b1;
      end
      ps2ap_pkg::REQ_STATUS_RD: res.read_data = status_q;
      ps2ap_pkg::REQ_DATA_WR: begin
        if (status_q[ps2ap_pkg::StTxIdle] && status_q[ps2ap_pkg::StEnable]) begin
          cmd_byte_q = item.wdata;
          status_q[ps2ap_pkg::StTxIdle] = 1'b0;
        end
      end
      ps2ap_pkg::REQ_CTRL_WR: begin
        status_q = (status_q & ps2ap_pkg::CtrlKeepMask) |
                   (item.wdata & ps2ap_pkg::CtrlWriteMask);
        if (status_q[ps2ap_pkg::StClear] || status_q[ps2ap_pkg::StReset]) begin
          status_q[ps2ap_pkg::StRxFull]  = 1'b0;
          status_q[ps2ap_pkg::StDevIdle] = 1'b1;
          status_q[ps2ap_pkg::StTxIdle]  = 1'b1;
        end
      end
      ps2ap_pkg::REQ_POLL: begin
        case (phase_q)
          ps2ap_pkg::PH_IBF, ps2ap_pkg::PH_MAIN: begin
            if (!status_q[ps2ap_pkg::StTxIdle]) begin
              // pending host byte goes out as a command
              status_q[ps2ap_pkg::StTxIdle] = 1'b1;
              status_q[ps2ap_pkg::StEnable] = 1'b1;
              res.cmd_valid = 1'b1;
              res.cmd_byte  = cmd_byte_q;
              phase_q = ps2ap_pkg::PH_SEND;
            end else if (phase_q == ps2ap_pkg::PH_MAIN) begin
              scan = 1'b1;
              phase_q = ps2ap_pkg::PH_IBF;
            end else if (!status_q[ps2ap_pkg::StRxFull] && status_q[ps2ap_pkg::StEnable]) begin
              phase_q = ps2ap_pkg::PH_MAIN;
            end
          end
          ps2ap_pkg::PH_SEND: if (!item.dev_cmd_pending) phase_q = ps2ap_pkg::PH_SCAN;
          default: scan = 1'b1;
        endcase
      end
      default: ;
    endcase
    // device scan: latch an offered byte
    if (scan && item.dev_byte_valid) begin
      status_q[ps2ap_pkg::StDevIdle] = 1'b0;
      status_q[ps2ap_pkg::StRxFull]  = 1'b1;
      res.irq_pulse     = status_q[ps2ap_pkg::StIntsOn];
      res.take_dev_byte = 1'b1;
      rx_byte_q = item.dev_byte;
      phase_q = ps2ap_pkg::PH_IBF;
    end
    return res;
  endfunction

  function automatic ps2ap_pkg::req_t make_req(input logic [2:0] code,
                                               input logic [7:0] wdata,
                                               input logic pend, input logic byte_vld,
                                               input logic [7:0] dev_byte);
    ps2ap_pkg::req_t item;
    item.req_type        = code;
    item.wdata           = wdata;
    item.dev_cmd_pending = pend;
    item.dev_byte_valid  = byte_vld;
    item.dev_byte        = dev_byte;
    return item;
  endfunction

  // Request of the given code with every other field random
  function automatic ps2ap_pkg::req_t rand_req(input logic [2:0] code);
    return make_req(code, 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // One request transfer, with bursts and random gaps in front
  task automatic send_req(input ps2ap_pkg::req_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_ch.valid   <= 1'b1;
    req_ch.payload <= item;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    aux_result_q.push_back(aux_port_predict(item));
    n_sent++;
  endtask

  // Reads right after reset: status 0x05 and output byte 0xFF
  task automatic test_reset_values();
    send_req(make_req(ps2ap_pkg::REQ_STATUS_RD, 8'h00, 1'b0, 1'b0, 8'h00));
    send_req(make_req(ps2ap_pkg::REQ_DATA_RD, 8'h00, 1'b0, 1'b0, 8'h00));
  endtask

  // Full command/response exchange walking every poll phase
  task automatic test_directed_exchange();
    // data write and poll are no-ops while enable is clear
    send_req(make_req(ps2ap_pkg::REQ_DATA_WR, 8'h3C, 1'b0, 1'b0, 8'h00));
    send_req(make_req(ps2ap_pkg::REQ_POLL, 8'h00, 1'b0, 1'b1, 8'h11));
    // all writable bits, clear and reset included
    send_req(make_req(ps2ap_pkg::REQ_CTRL_WR, 8'hFF, 1'b0, 1'b0, 8'h00));
    send_req(make_req(ps2ap_pkg::REQ_STATUS_RD, 8'h00, 1'b0, 1'b0, 8'h00));
    send_req(make_req(ps2ap_pkg::REQ_CTRL_WR, 8'h90, 1'b0, 1'b0, 8'h00));
    send_req(make_req(ps2ap_pkg::REQ_DATA_WR, 8'hA5, 1'b0, 1'b0, 8'h00));
    // second write while transmit is busy is dropped
    send_req(make_req(ps2ap_pkg::REQ_DATA_WR, 8'h00, 1'b0, 1'b0, 8'h00));
    send_req(make_req(ps2ap_pkg::REQ_POLL, 8'h00, 1'b1, 1'b0, 8'h00));
    send_req(make_req(ps2ap_pkg::REQ_POLL, 8'h00, 1'b1, 1'b1, 8'h22));
    send_req(make_req(ps2ap_pkg::REQ_POLL, 8'h00, 1'b0, 1'b0, 8'h00));
    send_req(make_req(ps2ap_pkg::REQ_POLL, 8'h00, 1'b0, 1'b0, 8'h33));
    send_req(make_req(ps2ap_pkg::REQ_POLL, 8'h00, 1'b0, 1'b1, 8'hFF));
    // receive full holds the sequencer in the input-buffer check
    send_req(make_req(ps2ap_pkg::REQ_POLL, 8'h00, 1'b0, 1'b1, 8'h44));
    send_req(make_req(ps2ap_pkg::REQ_STATUS_RD, 8'h00, 1'b0, 1'b0, 8'h00));
    send_req(make_req(ps2ap_pkg::REQ_DATA_RD, 8'h00, 1'b0, 1'b0, 8'h00));
    // idle scan path through the check-device phase
    send_req(make_req(ps2ap_pkg::REQ_POLL, 8'h00, 1'b0, 1'b0, 8'h00));
    send_req(make_req(ps2ap_pkg::REQ_POLL, 8'h00, 1'b0, 1'b1, 8'h00));
    // reset bit alone, clear bit alone, then enable with interrupts off
    send_req(make_req(ps2ap_pkg::REQ_CTRL_WR, 8'h08, 1'b0, 1'b0, 8'h00));
    send_req(make_req(ps2ap_pkg::REQ_CTRL_WR, 8'h40, 1'b0, 1'b0, 8'h00));
    send_req(make_req(ps2ap_pkg::REQ_CTRL_WR, 8'h80, 1'b0, 1'b0, 8'h00));
    send_req(make_req(ps2ap_pkg::REQ_POLL, 8'h00, 1'b0, 1'b0, 8'h00));
    send_req(make_req(ps2ap_pkg::REQ_DATA_WR, 8'h5A, 1'b0, 1'b0, 8'h00));
    // command start from the check-device phase
    send_req(make_req(ps2ap_pkg::REQ_POLL, 8'h00, 1'b0, 1'b0, 8'h00));
  endtask

  task automatic test_unused_codes();
    for (int c = ReqUnusedFirst; c <= ReqUnusedLast; c++) send_req(rand_req(3'(c)));
  endtask

  // Receiver holds off for a long stretch while requests keep coming
  task automatic test_back_pressure();
    gaps_on    = 1'b0;
    burst_left = 32;
    hold_left  = 60;
    repeat (16) begin
      send_req(rand_req(3'($urandom_range(ps2ap_pkg::REQ_DATA_RD, ps2ap_pkg::REQ_POLL))));
    end
  endtask

  // Mostly well-formed exchanges with random content, plus noise
  task automatic test_random_traffic();
    ps2ap_pkg::req_t item;
    while (n_sent < RandomItems) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 2) == 0) begin
          item = rand_req(ps2ap_pkg::REQ_CTRL_WR);
          item.wdata[ps2ap_pkg::StEnable] = 1'b1;
          if ($urandom_range(0, 3) != 0) begin
            item.wdata[ps2ap_pkg::StClear] = 1'b0;
            item.wdata[ps2ap_pkg::StReset] = 1'b0;
          end
          send_req(item);
        end
        if ($urandom_range(0, 3) == 0) send_req(rand_req(ps2ap_pkg::REQ_STATUS_RD));
        send_req(rand_req(ps2ap_pkg::REQ_DATA_WR));
        repeat ($urandom_range(1, 8)) begin
          item = rand_req(ps2ap_pkg::REQ_POLL);
          item.dev_cmd_pending = ($urandom_range(0, 2) == 0);
          item.dev_byte_valid  = ($urandom_range(0, 3) == 0);
          send_req(item);
        end
        if ($urandom_range(0, 1) == 0) send_req(rand_req(ps2ap_pkg::REQ_STATUS_RD));
        if ($urandom_range(0, 3) != 0) send_req(rand_req(ps2ap_pkg::REQ_DATA_RD));
      end else begin
        repeat ($urandom_range(1, 6)) send_req(rand_req(3'($urandom_range(0, 7))));
      end
    end
  endtask

  // Result receiver: long hold-off on request, else its own stall pattern
  initial begin : rsp_sink
    logic [15:0] rdy_pat;
    int unsigned slot;
    bit          always_rdy;
    rdy_pat    = 16'hFFFF;
    slot       = 0;
    always_rdy = 1'b1;
    rsp_ch.ready <= 1'b0;
    forever @(posedge clk_i) begin
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (slot == 0) begin
          slot       = $urandom_range(16, 96);
          always_rdy = ($urandom_range(0, 2) == 0);
          rdy_pat    = 16'($urandom) | 16'h0001;
        end
        slot--;
        rsp_ch.ready <= always_rdy | rdy_pat[0];
        rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
      end
    end
  end

  // Result checker against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (aux_result_q.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want_rsp = aux_result_q.pop_front();
        if (rsp_ch.payload.read_data !== want_rsp.read_data)
          report_mismatch($sformatf("read_data got %h want %h",
                                    rsp_ch.payload.read_data, want_rsp.read_data));
        if (rsp_ch.payload.cmd_valid !== want_rsp.cmd_valid)
          report_mismatch($sformatf("cmd_valid got %b want %b",
                                    rsp_ch.payload.cmd_valid, want_rsp.cmd_valid));
        if (rsp_ch.payload.cmd_byte !== want_rsp.cmd_byte)
          report_mismatch($sformatf("cmd_byte got %h want %h",
                                    rsp_ch.payload.cmd_byte, want_rsp.cmd_byte));
        if (rsp_ch.payload.take_dev_byte !== want_rsp.take_dev_byte)
          report_mismatch($sformatf("take_dev_byte got %b want %b",
                                    rsp_ch.payload.take_dev_byte, want_rsp.take_dev_byte));
        if (rsp_ch.payload.irq_pulse !== want_rsp.irq_pulse)
          report_mismatch($sformatf("irq_pulse got %b want %b",
                                    rsp_ch.payload.irq_pulse, want_rsp.irq_pulse));
      end
    end
  end

  // Watchdog: too many cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt == IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    err_cnt    = 0;
    n_sent     = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    hold_left  = 0;
    idle_cnt   = 0;
    status_q   = ps2ap_pkg::StatusReset;
    cmd_byte_q = 8'h00;
    rx_byte_q  = ps2ap_pkg::OutByteReset;
    phase_q    = ps2ap_pkg::PH_IBF;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_directed_exchange();
    test_unused_codes();
    test_back_pressure();
    test_random_traffic();

    // drain outstanding results
    req_ch.valid <= 1'b0;
    while (aux_result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ps2ap_pkg.sv
hw/rtl/ps2ap_if.sv
hw/rtl/ps2_aux_port_controller.sv
hw/rtl/ps2ap_checker.sv
tb/sv/ps2_aux_port_controller_test.sv
